// ----- rtl/double_ended_scratch_allocator_unit_defines.svh -----
// Assertion macros for the scratch allocator checker.
`ifndef DOUBLE_ENDED_SCRATCH_ALLOCATOR_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_SCRATCH_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DSAU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("dsau: assertion failed");

// Next-cycle implication, disabled while in reset.
`define DSAU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("dsau: assertion failed");

// Next-cycle implication that also covers reset cycles.
`define DSAU_ASSERT_ANY(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("dsau: assertion failed");

`endif

// ----- rtl/dsau_pkg.sv -----
package dsau_pkg;

  localparam int CNT_W       = 25;
  localparam int ALIGN_W     = 17;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 200;

  localparam logic [31:0] HEADER_BYTES = 32'd16;

  // request kinds
  localparam logic [2:0] KIND_HEAD_ALLOC  = 3'd0;
  localparam logic [2:0] KIND_TAIL_ALLOC  = 3'd1;
  localparam logic [2:0] KIND_RELEASE     = 3'd2;
  localparam logic [2:0] KIND_RESTORE     = 3'd3;
  localparam logic [2:0] KIND_ARENA_RESET = 3'd4;

  // result status
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_IGNORED    = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_INVALID    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN    = 3'd4;
  localparam logic [2:0] ST_NOT_RECENT = 3'd5;
  localparam logic [2:0] ST_BAD_CKPT   = 3'd6;

  // header side tags
  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_HEAD = 2'd1;
  localparam logic [1:0] SIDE_TAIL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ARENA_BASE    = 2'd0;
  localparam logic [1:0] CFG_ARENA_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_ALIGN = 2'd2;

  localparam logic [31:0]        BASE_RST   = 32'd0;
  localparam logic [31:0]        LIMIT_RST  = 32'd65536;
  localparam logic [ALIGN_W-1:0] DALIGN_RST = 17'd16;

endpackage

// ----- rtl/dsau_ram.sv -----
module dsau_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dsau_align.sv -----
module dsau_align
  import dsau_pkg::*;
(
  input  logic [ALIGN_W-1:0] align_request,
  input  logic [ALIGN_W-1:0] default_align,
  output logic [ALIGN_W:0]   align
);

  logic [ALIGN_W-1:0] req;
  logic [ALIGN_W-1:0] smear;

  // round up to a power of two, at least four
  always_comb begin
    req   = (align_request == '0) ? default_align : align_request;
    smear = req - ALIGN_W'(1);
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    if (req < ALIGN_W'(4)) begin
      align = (ALIGN_W+1)'(4);
    end else begin
      align = {1'b0, smear} + (ALIGN_W+1)'(1);
    end
  end

endmodule

// ----- rtl/double_ended_scratch_allocator_unit.sv -----
// Double-ended scratch allocator.
// Input channel in_*: one request per item; in_tuser carries the kind, in_tdata the
// operands. Result channel out_*: exactly one result per request, in order.
// Configuration port cfg_*: single-cycle writes, taken at any time; base and limit
// are sampled by the first request after reset and ignored afterwards, the default
// alignment is used at each request.
// Timing: a request is taken in the idle state, then goes through three steps: offset
// calculation with the header store read, cursor update with the header store write,
// and usage/peak update. The result is registered at the end of the last step; a new
// request is taken only after the previous one has left the last step.
// Reset: synchronous, active low. Afterwards the header store is swept clear at one
// entry per cycle, all ARENA_BYTES/4 entries, with in_tready held low.
// Stall: a result waits in the output register while out_tready is low; the next
// request is still taken and finishes up to the output register, then waits.
module double_ended_scratch_allocator_unit
  import dsau_pkg::*;
#(
  parameter int ARENA_BYTES = 65536
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // byte_count[31:0], align_request[48:32], target_addr[80:49], saved_tail[112:81]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind[2:0]
  input  logic [2:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[2:0], block_addr[34:3], head_addr[66:35], tail_addr[98:67],
  // bytes_used[123:99], bytes_peak[148:124], bytes_free[173:149],
  // bytes_total[198:174]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_wdata
);

  localparam int SLOT_COUNT = ARENA_BYTES / 4;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int OFF_W      = $clog2(ARENA_BYTES + 1);
  localparam int IDX_W      = OFF_W - 2;
  localparam int ENTRY_W    = 2 + 2 * OFF_W;
  localparam logic [IDX_W:0]    SLOT_V   = (IDX_W+1)'(SLOT_COUNT);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CALC, S_EXEC, S_STAT} state_t;

  state_t state_r, state_nxt;

  logic [31:0]        cfg_base_r, cfg_limit_r;
  logic [ALIGN_W-1:0] cfg_dalign_r;

  logic               started_r;
  logic [31:0]        base_r, limit_r, head_r, tail_r;
  logic [OFF_W-1:0]   peak_r;

  logic [2:0]         kind_r;
  logic [31:0]        n_r, tgt_r, stl_r;
  logic [ALIGN_W:0]   align_r;

  logic [32:0]        pos_r;
  logic               fail_r;
  logic [2:0]         rel_st_r;
  logic [31:0]        h_r;

  logic [2:0]         status_r;
  logic [31:0]        pay_r;
  logic               bump_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [ADDR_W-1:0]      clr_addr_r;

  logic               accept;
  logic               out_free;
  logic [ALIGN_W:0]   align_fix;

  // arena latch values
  logic [31:0] lat_base, lat_cap, lat_lim0, lat_limit;
  logic [32:0] lat_sum;

  // calc step
  logic [32:0]      mask33, hp_sum, head_pos, tail_pos;
  logic [32:0]      rel_floor;
  logic [31:0]      rel_h, rel_off;
  logic [IDX_W-1:0] rel_idx;
  logic [2:0]       rel_st;

  // exec step
  logic [ENTRY_W-1:0] rd_data;
  logic [1:0]         e_side;
  logic [OFF_W-1:0]   e_from, e_end, head_off;
  logic [33:0]        end34;
  logic [32:0]        tail_floor;
  logic [31:0]        hw_addr, hw_off, ex_head, ex_tail, ex_pay;
  logic [IDX_W-1:0]   hw_idx;
  logic [2:0]         ex_st;
  logic               ex_we, ex_clear_peak;
  logic [OFF_W-1:0]   ex_from, ex_end;

  // stat step
  logic [OFF_W-1:0] used, free_b, total_b, peak_new;

  // ram ports
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  dsau_align u_align (
    .align_request (in_tdata[48:32]),
    .default_align (cfg_dalign_r),
    .align         (align_fix)
  );

  always_comb begin
    lat_base  = {cfg_base_r[31:2], 2'b00};
    lat_sum   = {1'b0, lat_base} + 33'(ARENA_BYTES);
    lat_cap   = lat_sum[32] ? 32'hFFFF_FFFF : lat_sum[31:0];
    lat_lim0  = (cfg_limit_r < lat_base) ? lat_base : cfg_limit_r;
    lat_limit = (lat_lim0 > lat_cap) ? lat_cap : lat_lim0;
  end

  always_comb begin
    mask33    = ~(33'(align_r) - 33'd1);
    hp_sum    = {1'b0, head_r} + 33'(HEADER_BYTES) + 33'(align_r) - 33'd1;
    head_pos  = hp_sum & mask33;
    tail_pos  = ({1'b0, tail_r} - {1'b0, n_r}) & mask33;
    rel_floor = {1'b0, base_r} + 33'(HEADER_BYTES);
    rel_h     = tgt_r - HEADER_BYTES;
    rel_off   = rel_h - base_r;
    rel_idx   = rel_off[OFF_W-1:2];
    if (tgt_r == '0) begin
      rel_st = ST_IGNORED;
    end else if (({1'b0, tgt_r} < rel_floor) || (tgt_r > limit_r) || (rel_h >= limit_r)) begin
      rel_st = ST_INVALID;
    end else if ((rel_off[1:0] != 2'b00) || ({1'b0, rel_idx} >= SLOT_V)) begin
      rel_st = ST_UNKNOWN;
    end else begin
      rel_st = ST_OK;
    end
  end

  always_comb begin
    e_side     = rd_data[ENTRY_W-1 -: 2];
    e_from     = rd_data[2*OFF_W-1 -: OFF_W];
    e_end      = rd_data[OFF_W-1:0];
    head_off   = OFF_W'(head_r - base_r);
    end34      = {1'b0, pos_r} + 34'(n_r);
    tail_floor = {1'b0, head_r} + 33'(HEADER_BYTES);
    hw_addr    = pos_r[31:0] - HEADER_BYTES;
    hw_off     = hw_addr - base_r;
    hw_idx     = hw_off[OFF_W-1:2];
    ex_st         = ST_OK;
    ex_head       = head_r;
    ex_tail       = tail_r;
    ex_pay        = '0;
    ex_we         = 1'b0;
    ex_clear_peak = 1'b0;
    ex_from       = head_off;
    ex_end        = OFF_W'(end34[31:0] - base_r);
    case (kind_r)
      KIND_HEAD_ALLOC: begin
        if (n_r == '0) begin
          ex_st = ST_IGNORED;
        end else if ((end34[33:32] != 2'b00) || (end34[31:0] > tail_r)) begin
          ex_st = ST_NO_SPACE;
        end else begin
          ex_head = end34[31:0];
          ex_pay  = pos_r[31:0];
          ex_we   = 1'b1;
        end
      end
      KIND_TAIL_ALLOC: begin
        ex_from = OFF_W'(tail_r - base_r);
        ex_end  = OFF_W'(hw_off);
        if (n_r == '0) begin
          ex_st = ST_IGNORED;
        end else if (fail_r || (pos_r < tail_floor)) begin
          ex_st = ST_NO_SPACE;
        end else begin
          ex_tail = hw_addr;
          ex_pay  = pos_r[31:0];
          ex_we   = 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (rel_st_r != ST_OK) begin
          ex_st = rel_st_r;
        end else begin
          case (e_side)
            SIDE_HEAD: begin
              if (head_off == e_end) begin
                ex_head = base_r + 32'(e_from);
              end else begin
                ex_st = ST_NOT_RECENT;
              end
            end
            SIDE_TAIL: begin
              if (h_r == tail_r) begin
                ex_tail = base_r + 32'(e_from);
              end else begin
                ex_st = ST_NOT_RECENT;
              end
            end
            default: ex_st = ST_UNKNOWN;
          endcase
        end
      end
      KIND_RESTORE: begin
        if ((tgt_r < base_r) || (tgt_r > limit_r) || (stl_r < base_r) ||
            (stl_r > limit_r) || (tgt_r > stl_r)) begin
          ex_st = ST_BAD_CKPT;
        end else begin
          ex_head = tgt_r;
          ex_tail = stl_r;
        end
      end
      KIND_ARENA_RESET: begin
        ex_head       = base_r;
        ex_tail       = limit_r;
        ex_clear_peak = 1'b1;
      end
      default: ex_st = ST_IGNORED;
    endcase
  end

  always_comb begin
    used     = OFF_W'(head_r - base_r) + OFF_W'(limit_r - tail_r);
    free_b   = OFF_W'(tail_r - head_r);
    total_b  = OFF_W'(limit_r - base_r);
    peak_new = (bump_r && (used > peak_r)) ? used : peak_r;
  end

  always_comb begin
    ram_re    = (state_r == S_CALC) && (kind_r == KIND_RELEASE);
    ram_raddr = rel_idx[ADDR_W-1:0];
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == S_EXEC) && ex_we && ({1'b0, hw_idx} < SLOT_V);
      ram_waddr = hw_idx[ADDR_W-1:0];
      ram_wdata = {(kind_r == KIND_HEAD_ALLOC) ? SIDE_HEAD : SIDE_TAIL, ex_from, ex_end};
    end
  end

  dsau_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_addr_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_CALC;
      S_CALC:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_STAT;
      S_STAT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      cfg_base_r   <= BASE_RST;
      cfg_limit_r  <= LIMIT_RST;
      cfg_dalign_r <= DALIGN_RST;
      base_r       <= '0;
      limit_r      <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      peak_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ARENA_BASE:    cfg_base_r   <= cfg_wdata;
          CFG_ARENA_LIMIT:   cfg_limit_r  <= cfg_wdata;
          CFG_DEFAULT_ALIGN: cfg_dalign_r <= cfg_wdata[ALIGN_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (out_valid_r && out_tready && (state_r != S_STAT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r  <= in_tuser;
            n_r     <= in_tdata[31:0];
            tgt_r   <= in_tdata[80:49];
            stl_r   <= in_tdata[112:81];
            align_r <= align_fix;
            if (!started_r) begin
              started_r <= 1'b1;
              base_r    <= lat_base;
              limit_r   <= lat_limit;
              head_r    <= lat_base;
              tail_r    <= lat_limit;
              peak_r    <= '0;
            end
          end
        end
        S_CALC: begin
          pos_r    <= (kind_r == KIND_HEAD_ALLOC) ? head_pos : tail_pos;
          fail_r   <= n_r > (tail_r - head_r);
          rel_st_r <= rel_st;
          h_r      <= rel_h;
        end
        S_EXEC: begin
          head_r   <= ex_head;
          tail_r   <= ex_tail;
          status_r <= ex_st;
          pay_r    <= ex_pay;
          bump_r   <= (ex_st == ST_OK) &&
                      ((kind_r == KIND_HEAD_ALLOC) || (kind_r == KIND_TAIL_ALLOC));
          if (ex_clear_peak) begin
            peak_r <= '0;
          end
        end
        S_STAT: begin
          if (out_free) begin
            peak_r      <= peak_new;
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0, CNT_W'(total_b), CNT_W'(free_b), CNT_W'(peak_new),
                            CNT_W'(used), tail_r, head_r, pay_r, status_r};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/dsau_checker.sv -----
`include "double_ended_scratch_allocator_unit_defines.svh"

module dsau_checker
  import dsau_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `DSAU_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // header sweep keeps the input closed right after reset
  `DSAU_ASSERT_ANY(a_rst_closed, clk, !rst_n, !in_tready)

  // one request at a time
  `DSAU_ASSERT_NXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready)

  `DSAU_ASSERT_IMP(a_pay_zero, clk, rst_n, out_tvalid && (out_tdata[2:0] != ST_OK), out_tdata[34:3] == 32'd0)

  // used plus free always spans the arena
  `DSAU_ASSERT_IMP(a_usage_sum, clk, rst_n, out_tvalid, out_tdata[123:99] + out_tdata[173:149] == out_tdata[198:174])

endmodule

bind double_ended_scratch_allocator_unit dsau_checker u_checker (.*);

// ----- dv/double_ended_scratch_allocator_unit_test.sv -----
`timescale 1ns / 1ps

module double_ended_scratch_allocator_unit_test;
  import dsau_pkg::*;

  localparam int ARENA_BYTES = 65536;
  localparam int SLOTS = ARENA_BYTES / 4;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 80000;
  localparam int HISTORY = 8;

  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
  localparam logic [1:0] CFG_UNUSED        = 2'd3;

  typedef struct {
    logic [2:0]       status;
    logic [31:0]      payload;
    logic [31:0]      head;
    logic [31:0]      tail;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] peak;
    logic [CNT_W-1:0] free;
    logic [CNT_W-1:0] total;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [31:0]        reg_base = BASE_RST;
    logic [31:0]        reg_limit = LIMIT_RST;
    logic [ALIGN_W-1:0] reg_dalign = DALIGN_RST;
    bit                 started;
    bit [63:0]          base_q, limit_q, head_q, tail_q, peak_q;
    bit [1:0]           hdr_side [SLOTS];
    bit [31:0]          hdr_from [SLOTS];
    bit [31:0]          hdr_span [SLOTS];
    alloc_result_t      pending_results[$];
    int                 mismatches;
    // bookkeeping for building meaningful requests
    logic [31:0]        head_live[$], tail_live[$], recent_payloads[$];
    logic [31:0]        ckpt_head[$], ckpt_tail[$];

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void note_config(logic [1:0] idx, logic [31:0] v);
      case (idx)
        CFG_ARENA_BASE:    reg_base = v;
        CFG_ARENA_LIMIT:   reg_limit = v;
        CFG_DEFAULT_ALIGN: reg_dalign = v[ALIGN_W-1:0];
        default: ;
      endcase
    endfunction

    function void latch_arena();
      bit [63:0] b, l, cap;
      if (started) return;
      b = {32'd0, reg_base[31:2], 2'b00};
      l = 64'(reg_limit);
      if (l < b) l = b;
      cap = b + 64'(ARENA_BYTES);
      if (cap > 64'hFFFF_FFFF) cap = 64'hFFFF_FFFF;
      if (l > cap) l = cap;
      base_q = b;
      limit_q = l;
      head_q = b;
      tail_q = l;
      peak_q = 0;
      started = 1'b1;
    endfunction

    function bit [63:0] eff_align(logic [ALIGN_W-1:0] req);
      bit [63:0] a, p;
      a = (req == 0) ? 64'(reg_dalign) : 64'(req);
      if (a < 4) a = 4;
      if ((a & (a - 1)) != 0) begin
        p = 4;
        while (p < a) p = p << 1;
        a = p;
      end
      return a;
    endfunction

    function bit [63:0] usage();
      return (head_q - base_q) + (limit_q - tail_q);
    endfunction

    function bit [63:0] free_bytes();
      return tail_q - head_q;
    endfunction

    function void bump_peak();
      if (usage() > peak_q) peak_q = usage();
    endfunction

    function void store_header(bit [63:0] at, bit [1:0] side, bit [63:0] from,
                               bit [63:0] span);
      bit [63:0] idx;
      idx = (at - base_q) >> 2;
      if (idx >= SLOTS) return;
      hdr_side[idx] = side;
      hdr_from[idx] = from[31:0];
      hdr_span[idx] = span[31:0];
    endfunction

    function logic [2:0] grab_head(bit [63:0] n, bit [63:0] a, output bit [63:0] pay);
      bit [63:0] p, top;
      pay = 0;
      if (n == 0) return ST_IGNORED;
      p = (head_q + 64'(HEADER_BYTES) + a - 1) & ~(a - 1);
      if (p > 64'hFFFF_FFFF - n) return ST_NO_SPACE;
      top = p + n;
      if (top > tail_q) return ST_NO_SPACE;
      store_header(p - 64'(HEADER_BYTES), SIDE_HEAD, head_q, top - head_q);
      head_q = top;
      bump_peak();
      pay = p;
      return ST_OK;
    endfunction

    function logic [2:0] grab_tail(bit [63:0] n, bit [63:0] a, output bit [63:0] pay);
      bit [63:0] p, h;
      pay = 0;
      if (n == 0) return ST_IGNORED;
      if (n > tail_q - head_q) return ST_NO_SPACE;
      p = (tail_q - n) & ~(a - 1);
      if (p < head_q + 64'(HEADER_BYTES)) return ST_NO_SPACE;
      h = p - 64'(HEADER_BYTES);
      store_header(h, SIDE_TAIL, tail_q, tail_q - h);
      tail_q = h;
      bump_peak();
      pay = p;
      return ST_OK;
    endfunction

    function logic [2:0] release_block(bit [63:0] p);
      bit [63:0] h, off, idx;
      if (p == 0) return ST_IGNORED;
      if (p < base_q + 64'(HEADER_BYTES) || p > limit_q) return ST_INVALID;
      h = p - 64'(HEADER_BYTES);
      if (h < base_q || h >= limit_q) return ST_INVALID;
      off = h - base_q;
      if (off[1:0] != 2'b00) return ST_UNKNOWN;
      idx = off >> 2;
      if (idx >= SLOTS) return ST_UNKNOWN;
      if (hdr_side[idx] == SIDE_HEAD) begin
        if (head_q == 64'(hdr_from[idx]) + 64'(hdr_span[idx])) begin
          head_q = 64'(hdr_from[idx]);
          return ST_OK;
        end
        return ST_NOT_RECENT;
      end
      if (hdr_side[idx] == SIDE_TAIL) begin
        if (h == tail_q) begin
          tail_q = 64'(hdr_from[idx]);
          return ST_OK;
        end
        return ST_NOT_RECENT;
      end
      return ST_UNKNOWN;
    endfunction

    function logic [2:0] restore_cursors(bit [63:0] hd, bit [63:0] tl);
      if (hd < base_q || hd > limit_q || tl < base_q || tl > limit_q || hd > tl)
        return ST_BAD_CKPT;
      head_q = hd;
      tail_q = tl;
      return ST_OK;
    endfunction

    function alloc_result_t predict_alloc_result(logic [2:0] kind, logic [31:0] n,
                                                 logic [ALIGN_W-1:0] areq,
                                                 logic [31:0] tgt, logic [31:0] stl);
      alloc_result_t r;
      bit [63:0] pay, u, fr, tot;
      logic [2:0] st;
      pay = 0;
      latch_arena();
      case (kind)
        KIND_HEAD_ALLOC: st = grab_head(64'(n), eff_align(areq), pay);
        KIND_TAIL_ALLOC: st = grab_tail(64'(n), eff_align(areq), pay);
        KIND_RELEASE:    st = release_block(64'(tgt));
        KIND_RESTORE:    st = restore_cursors(64'(tgt), 64'(stl));
        KIND_ARENA_RESET: begin
          head_q = base_q;
          tail_q = limit_q;
          peak_q = 0;
          st = ST_OK;
        end
        default: st = ST_IGNORED;
      endcase
      if (st != ST_OK) pay = 0;
      u = usage();
      fr = free_bytes();
      tot = limit_q - base_q;
      r.status = st;
      r.payload = pay[31:0];
      r.head = head_q[31:0];
      r.tail = tail_q[31:0];
      r.used = u[CNT_W-1:0];
      r.peak = peak_q[CNT_W-1:0];
      r.free = fr[CNT_W-1:0];
      r.total = tot[CNT_W-1:0];
      return r;
    endfunction

    function void note_request(logic [2:0] kind, logic [31:0] n, logic [ALIGN_W-1:0] areq,
                               logic [31:0] tgt, logic [31:0] stl);
      alloc_result_t r;
      r = predict_alloc_result(kind, n, areq, tgt, stl);
      pending_results.push_back(r);
      if (r.status == ST_OK) begin
        case (kind)
          KIND_HEAD_ALLOC: head_live.push_back(r.payload);
          KIND_TAIL_ALLOC: tail_live.push_back(r.payload);
          KIND_RELEASE: begin
            if (head_live.size() > 0 && head_live[$] == tgt) void'(head_live.pop_back());
            else if (tail_live.size() > 0 && tail_live[$] == tgt)
              void'(tail_live.pop_back());
          end
          default: begin
            head_live.delete();
            tail_live.delete();
          end
        endcase
        if (kind == KIND_HEAD_ALLOC || kind == KIND_TAIL_ALLOC) begin
          recent_payloads.push_back(r.payload);
          if (recent_payloads.size() > HISTORY) void'(recent_payloads.pop_front());
        end
      end
      ckpt_head.push_back(r.head);
      ckpt_tail.push_back(r.tail);
      if (ckpt_head.size() > HISTORY) begin
        void'(ckpt_head.pop_front());
        void'(ckpt_tail.pop_front());
      end
    endfunction

    function logic [31:0] pick_release_target();
      int r;
      r = $urandom_range(0, 9);
      if (r < 8 && (head_live.size() > 0 || tail_live.size() > 0)) begin
        if (tail_live.size() == 0 || (head_live.size() > 0 && $urandom_range(0, 1) == 0))
          return head_live[$];
        return tail_live[$];
      end
      if (recent_payloads.size() > 0)
        return recent_payloads[$urandom_range(0, recent_payloads.size() - 1)];
      return 32'(base_q + 64'(HEADER_BYTES));
    endfunction

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] d);
      alloc_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0h with nothing expected", d));
        return;
      end
      e = pending_results.pop_front();
      compare("status", 32'(d[2:0]), 32'(e.status));
      compare("block_addr", d[34:3], e.payload);
      compare("head_addr", d[66:35], e.head);
      compare("tail_addr", d[98:67], e.tail);
      compare("bytes_used", 32'(d[123:99]), 32'(e.used));
      compare("bytes_peak", 32'(d[148:124]), 32'(e.peak));
      compare("bytes_free", 32'(d[173:149]), 32'(e.free));
      compare("bytes_total", 32'(d[198:174]), 32'(e.total));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [2:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [1:0]             cfg_index;
  logic [31:0]            cfg_wdata;

  bit calm;
  bit hold_req;
  alloc_scoreboard sb = new();

  double_ended_scratch_allocator_unit #(
    .ARENA_BYTES(ARENA_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.note_config(idx, v);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [2:0] kind, input logic [31:0] n,
                           input logic [ALIGN_W-1:0] al, input logic [31:0] tgt,
                           input logic [31:0] stl);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {7'd0, stl, tgt, al, n};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, n, al, tgt, stl);
  endtask

  task automatic idle_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 19))
      0: return 32'd0;
      1: return $urandom;
      2, 3: return $urandom_range(65, 2048);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic logic [ALIGN_W-1:0] rand_align();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4: return 17'($urandom_range(1, 3));
      5: return 17'($urandom_range(5, 200));
      6: return ($urandom_range(0, 1) == 0) ? 17'd65536 : 17'($urandom_range(1024, 65535));
      default: return 17'(1 << $urandom_range(2, 6));
    endcase
  endfunction

  task automatic send_random_item();
    int r;
    int idx;
    logic [2:0] kind;
    logic [31:0] n, tgt, stl;
    logic [ALIGN_W-1:0] al;
    r = $urandom_range(0, 99);
    n = rand_size();
    al = rand_align();
    tgt = $urandom;
    stl = $urandom;
    if (sb.free_bytes() < 64 && $urandom_range(0, 3) == 0) r = 90;
    if (r < 33) begin
      kind = KIND_HEAD_ALLOC;
    end else if (r < 63) begin
      kind = KIND_TAIL_ALLOC;
    end else if (r < 83) begin
      kind = KIND_RELEASE;
      tgt = sb.pick_release_target();
    end else if (r < 89) begin
      kind = KIND_RESTORE;
      idx = $urandom_range(0, sb.ckpt_head.size() - 1);
      case ($urandom_range(0, 9))
        0: begin
          tgt = sb.ckpt_tail[idx];
          stl = sb.ckpt_head[idx];
        end
        1: ;
        default: begin
          tgt = sb.ckpt_head[idx];
          stl = sb.ckpt_tail[idx];
        end
      endcase
    end else if (r < 92) begin
      kind = KIND_ARENA_RESET;
    end else begin
      kind = 3'($urandom_range(0, 7));
      n = $urandom;
      al = 17'($urandom_range(0, 65536));
    end
    send_item(kind, n, al, tgt, stl);
  endtask

  task automatic run_directed();
    int k;
    logic [31:0] tgt;
    send_item(KIND_HEAD_ALLOC, 32'd1, 17'd0, 32'd0, 32'd0);
    send_item(KIND_TAIL_ALLOC, 32'd1, 17'd1, '1, '1);
    send_item(KIND_HEAD_ALLOC, 32'd0, 17'd0, $urandom, $urandom);
    send_item(KIND_TAIL_ALLOC, 32'd0, 17'd0, $urandom, $urandom);
    send_item(KIND_HEAD_ALLOC, 32'd100, 17'd3, 32'd0, 32'd0);
    send_item(KIND_HEAD_ALLOC, 32'd8, 17'd65536, 32'd0, 32'd0);
    send_item(KIND_HEAD_ALLOC, '1, 17'd16, 32'd0, 32'd0);
    send_item(KIND_TAIL_ALLOC, '1, 17'd16, 32'd0, 32'd0);
    send_item(KIND_TAIL_ALLOC, 32'd20, 17'd48, 32'd0, 32'd0);
    send_item(KIND_HEAD_ALLOC, 32'd24, 17'd0, 32'd0, 32'd0);
    send_item(KIND_RELEASE, 32'd0, 17'd0, 32'd0, 32'd0);
    send_item(KIND_RELEASE, 32'd0, 17'd0, '1, 32'd0);
    send_item(KIND_RELEASE, 32'd0, 17'd0, 32'(sb.base_q + 64'd18), 32'd0);
    // older head block: not the most recent on its side
    send_item(KIND_RELEASE, 32'd0, 17'd0, sb.recent_payloads[0], 32'd0);
    tgt = (sb.head_live.size() > 0) ? sb.head_live[$] :
                                      32'(sb.base_q + 64'(HEADER_BYTES));
    send_item(KIND_RELEASE, 32'd0, 17'd0, tgt, 32'd0);
    tgt = (sb.tail_live.size() > 0) ? sb.tail_live[$] : sb.limit_q[31:0];
    send_item(KIND_RELEASE, 32'd0, 17'd0, tgt, 32'd0);
    // stale header left behind by the release above
    send_item(KIND_RELEASE, 32'd0, 17'd0, tgt, 32'd0);
    send_item(KIND_RESTORE, 32'd0, 17'd0, sb.limit_q[31:0], sb.base_q[31:0]);
    send_item(KIND_RESTORE, 32'd0, 17'd0, 32'd0, '1);
    send_item(KIND_RESTORE, 32'd0, 17'd0, sb.base_q[31:0], sb.limit_q[31:0]);
    send_item(KIND_HEAD_ALLOC, 32'd32, 17'd0, 32'd0, 32'd0);
    send_item(KIND_ARENA_RESET, $urandom, 17'd0, $urandom, $urandom);
    for (k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
      send_item(3'(k), $urandom, 17'($urandom_range(0, 65536)), $urandom, $urandom);
  endtask

  // result side
  initial begin
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        stall = calm ? 0 : $urandom_range(0, 6);
      end
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        stall = 0;
        out_tready <= 1'b1;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("double_ended_scratch_allocator_unit_test NOT OK");
    $finish;
  end

  initial begin
    int ph, i;
    logic [31:0] base_w, limit_w;
    logic [ALIGN_W-1:0] dalign_set [PHASES];
    dalign_set = '{17'd16, 17'd0, 17'd65536, 17'd1, 17'd3, 17'd4, 17'd100, 17'd8};
    dalign_set[PHASES-1] = 17'($urandom_range(0, 65536));
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // arena is latched once by the first item, so its shape is picked here
    case ($urandom_range(0, 2))
      0: begin
        base_w = 32'h0000_0003;
        limit_w = '1;
      end
      1: begin
        base_w = 32'hFFFF_C001;
        limit_w = '1;
      end
      default: begin
        base_w = $urandom_range(0, 32'hFFFE_0000);
        limit_w = base_w + $urandom_range(256, 4096);
      end
    endcase
    write_reg(CFG_ARENA_BASE, base_w);
    write_reg(CFG_ARENA_LIMIT, limit_w);
    write_reg(CFG_DEFAULT_ALIGN, 32'(DALIGN_RST));
    run_directed();

    for (ph = 0; ph < PHASES; ph++) begin
      idle_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_reg(CFG_ARENA_BASE, $urandom);
      write_reg(CFG_ARENA_LIMIT, (ph == 0) ? 32'd0 : $urandom);
      write_reg(CFG_DEFAULT_ALIGN, 32'(dalign_set[ph]));
      if (ph == 0) write_reg(CFG_UNUSED, $urandom);
      calm = (ph == 2 || ph == 5);
      if (ph == 2) hold_req = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) idle_until_drained();
        send_random_item();
      end
    end
    calm = 1'b0;

    idle_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("double_ended_scratch_allocator_unit_test OK");
    end else begin
      $display("double_ended_scratch_allocator_unit_test NOT OK");
    end
    $finish;
  end

endmodule
